@@ rtl/sqs_pkg.sv @@
// Shared types, widths and the quarter-wave sine table builder for the sprite quad setup.
// No dependencies; every other file in rtl/ imports this package.
package sqs_pkg;

  localparam int ANGLE_STEPS    = 4096;
  localparam int SINE_FRAC_BITS = 15;
  localparam int ANGLE_BITS     = $clog2(ANGLE_STEPS);
  localparam int QUARTER        = ANGLE_STEPS / 4;
  localparam int QIDX_W         = $clog2(QUARTER + 1);
  localparam int SIN_W          = SINE_FRAC_BITS + 1;   // magnitude 0..1.0
  localparam int SC_W           = SINE_FRAC_BITS + 2;   // signed sine or cosine
  localparam int ROT_SH         = 9 + SINE_FRAC_BITS;   // 2^-13 px times Q.15 down to Q.4
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int POS_W   = 16;
  localparam int HALF_W  = 29;                          // src size times scale
  localparam int PROD_W  = HALF_W + 1 + SC_W;
  localparam int OFF_W   = PROD_W + 1;
  localparam int VERT_W  = 22;

  localparam int EDGE_W   = 14;
  localparam int SIZE_W   = 13;
  localparam int FRAC_W   = 16;
  localparam int COORD_W  = FRAC_W + 1;
  localparam int DIV_STEP = 4;
  localparam int DIV_STG  = FRAC_W / DIV_STEP;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int VERTS    = 6;
  localparam int IDX_W    = $clog2(VERTS);

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  // input word, last listed field in the low bits
  typedef struct packed {
    logic [5:0]              pad;
    logic [SIZE_W-1:0]       tex_height;
    logic [SIZE_W-1:0]       tex_width;
    logic [SIZE_W-1:0]       src_h;
    logic [SIZE_W-1:0]       src_w;
    logic [11:0]             src_v;
    logic [11:0]             src_u;
    logic                    flip_v;
    logic                    flip_h;
    logic [11:0]             angle;
    logic [15:0]             scale;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } sqs_in_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic [COORD_W-1:0] tex_v;
    logic [COORD_W-1:0] tex_u;
    logic [VERT_W-1:0]  vert_y;
    logic [VERT_W-1:0]  vert_x;
  } sqs_out_t;

  // one finished quad: four placed corners and the four texture edges
  typedef struct packed {
    logic [3:0][VERT_W-1:0] vx;
    logic [3:0][VERT_W-1:0] vy;
    logic [COORD_W-1:0]     ua;
    logic [COORD_W-1:0]     ub;
    logic [COORD_W-1:0]     va;
    logic [COORD_W-1:0]     vb;
  } sqs_entry_t;

  typedef logic [SIN_W-1:0] sine_rom_t [QUARTER+1];

  function automatic longint unsigned taylor_div(int n, longint unsigned t);
    case (n)
      1:       return t / 6;
      2:       return t / 20;
      3:       return t / 42;
      4:       return t / 72;
      5:       return t / 110;
      6:       return t / 156;
      default: return t / 210;
    endcase
  endfunction

  // Taylor series in Q30, seven correction terms, rounded half up to Q1.15
  function automatic logic [SIN_W-1:0] quarter_sine(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    longint          one;
    x    = (longint'(k) * HALF_PI_Q30) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    one  = longint'(1) << SINE_FRAC_BITS;
    for (int n = 1; n <= 7; n++) begin
      term = taylor_div(n, (term * x2) >> 30);
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + (longint'(1) << (29 - SINE_FRAC_BITS))) >>> (30 - SINE_FRAC_BITS);
    if (r > one) r = one;
    return SIN_W'(r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= QUARTER; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

  function automatic corner_e corner_of(logic [IDX_W-1:0] idx);
    case (idx)
      3'd0:    return CORNER_TL;
      3'd1:    return CORNER_TR;
      3'd2:    return CORNER_BR;
      3'd3:    return CORNER_TL;
      3'd4:    return CORNER_BR;
      3'd5:    return CORNER_BL;
      default: return CORNER_TL;
    endcase
  endfunction

endpackage

@@ rtl/sqs_tex_div.sv @@
// Pipelined restoring divider for one texture coordinate: round(edge * 65536 / size).
// Depends on sqs_pkg; takes a new operand pair every cycle.
module sqs_tex_div (
  input  logic                          clk_i,
  input  logic [sqs_pkg::EDGE_W-1:0]    tedge_i,
  input  logic [sqs_pkg::SIZE_W-1:0]    size_i,   // nonzero
  output logic [sqs_pkg::COORD_W-1:0]   coord_o
);
  import sqs_pkg::*;

  localparam int REM_W = SIZE_W + 1;

  logic [REM_W-1:0]  rem_q  [DIV_STG];
  logic [FRAC_W-1:0] low_q  [DIV_STG];
  logic [FRAC_W-1:0] quo_q  [DIV_STG];
  logic [SIZE_W-1:0] size_q [DIV_STG];
  logic              sat_q  [DIV_STG];

  for (genvar g = 0; g < DIV_STG; g++) begin : g_stage
    logic [REM_W-1:0]  rem_p;
    logic [FRAC_W-1:0] low_p;
    logic [FRAC_W-1:0] quo_p;
    logic [SIZE_W-1:0] size_p;
    logic              sat_p;
    logic [REM_W-1:0]  rem_d;
    logic [FRAC_W-1:0] low_d;
    logic [FRAC_W-1:0] quo_d;
    logic [SIZE_W-1:0] size_d;
    logic              sat_d;

    if (g == 0) begin : g_first
      assign rem_p  = REM_W'(tedge_i);
      assign low_p  = FRAC_W'(size_i >> 1);
      assign quo_p  = '0;
      assign size_p = size_i;
      assign sat_p  = tedge_i >= EDGE_W'(size_i);
    end else begin : g_next
      assign rem_p  = rem_q[g-1];
      assign low_p  = low_q[g-1];
      assign quo_p  = quo_q[g-1];
      assign size_p = size_q[g-1];
      assign sat_p  = sat_q[g-1];
    end

    always_comb begin
      logic [REM_W-1:0] t;
      rem_d  = rem_p;
      low_d  = low_p;
      quo_d  = quo_p;
      size_d = size_p;
      sat_d  = sat_p;
      // shift in one numerator bit per step, subtract where it fits
      for (int j = 0; j < DIV_STEP; j++) begin
        t     = {rem_d[REM_W-2:0], low_d[FRAC_W-1]};
        low_d = {low_d[FRAC_W-2:0], 1'b0};
        if (t >= {1'b0, size_d}) begin
          t     = t - {1'b0, size_d};
          quo_d = {quo_d[FRAC_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[FRAC_W-2:0], 1'b0};
        end
        rem_d = t;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      low_q[g]  <= low_d;
      quo_q[g]  <= quo_d;
      size_q[g] <= size_d;
      sat_q[g]  <= sat_d;
    end
  end

  // edge at or past the size means 1.0 or more: clamp
  assign coord_o = sat_q[DIV_STG-1] ? COORD_W'(1 << FRAC_W) : {1'b0, quo_q[DIV_STG-1]};

endmodule

@@ rtl/sqs_front.sv @@
// Front part: accepts requests, looks up sine and cosine, rotates the four corners and
// divides the texture edges. Depends on sqs_pkg and sqs_tex_div; fixed five-stage pipe.
module sqs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sqs_pkg::sqs_in_t     in_data_i,
  input  logic                 pop_i,      // credit back from the queue
  output logic                 push_o,
  output sqs_pkg::sqs_entry_t  entry_o
);
  import sqs_pkg::*;

  localparam sine_rom_t SineRom = build_sine_rom();
  localparam logic signed [OFF_W-1:0] RoundHalf = OFF_W'(longint'(1) << (ROT_SH - 1));
  localparam logic signed [OFF_W-1:0] PosMax = OFF_W'((longint'(1) << (VERT_W - 1)) - 1);
  localparam logic signed [OFF_W-1:0] PosMin = -OFF_W'(longint'(1) << (VERT_W - 1));

  logic              acc;
  logic [QCNT_W-1:0] occ_q, occ_d;
  logic [5:1]        vld_q;

  // angle split into quadrant and table index
  logic [ANGLE_BITS-1:0] ang_s, ang_c;
  logic [QIDX_W-1:0]     idx_s, idx_c;

  // stage 1
  logic signed [POS_W-1:0] px1_q, py1_q;
  logic [HALF_W-1:0]       hw1_q, hh1_q;
  logic [SIN_W-1:0]        smag1_q, cmag1_q;
  logic                    sneg1_q, cneg1_q;
  logic [EDGE_W-1:0]       uea1_q, ueb1_q, vea1_q, veb1_q;
  logic [SIZE_W-1:0]       tw1_q, th1_q;
  logic [5:1]              fh_q, fv_q;
  // stage 2
  logic signed [POS_W-1:0] px2_q, py2_q;
  logic [HALF_W-1:0]       hw2_q, hh2_q;
  logic signed [SC_W-1:0]  sin2_q, cos2_q;
  // stage 3
  logic signed [POS_W-1:0]  px3_q, py3_q;
  logic signed [PROD_W-1:0] pa3_q, pb3_q, pc3_q, pd3_q;
  // stage 4
  logic signed [POS_W-1:0] px4_q, py4_q;
  logic signed [OFF_W-1:0] ox4_q [4];
  logic signed [OFF_W-1:0] oy4_q [4];
  logic signed [OFF_W-1:0] ox4_d [4];
  logic signed [OFF_W-1:0] oy4_d [4];
  // stage 5
  logic [VERT_W-1:0] vx5_q [4];
  logic [VERT_W-1:0] vy5_q [4];
  logic [VERT_W-1:0] vx5_d [4];
  logic [VERT_W-1:0] vy5_d [4];

  logic [COORD_W-1:0] ua5, ub5, va5, vb5;

  function automatic logic [VERT_W-1:0] place(logic signed [OFF_W-1:0] off,
                                              logic signed [POS_W-1:0] pos);
    logic signed [OFF_W-1:0] t;
    t = (off + (OFF_W'(pos) <<< (ROT_SH + 4))) >>> ROT_SH;
    if (t > PosMax) t = PosMax;
    if (t < PosMin) t = PosMin;
    return t[VERT_W-1:0];
  endfunction

  assign in_ready_o = occ_q < QCNT_W'(QDEPTH);
  assign acc        = in_valid_i && in_ready_o;

  // occupancy covers the pipe and the queue, so a push always finds room
  always_comb begin
    occ_d = occ_q;
    if (acc && !pop_i)      occ_d = occ_q + 1'b1;
    else if (!acc && pop_i) occ_d = occ_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      vld_q <= '0;
    end else begin
      occ_q <= occ_d;
      vld_q <= {vld_q[4:1], acc};
    end
  end

  always_comb begin
    ang_s = ANGLE_BITS'(in_data_i.angle);
    ang_c = ang_s + ANGLE_BITS'(QUARTER);
    idx_s = ang_s[ANGLE_BITS-2] ? QIDX_W'(QUARTER) - QIDX_W'(ang_s[ANGLE_BITS-3:0])
                                : QIDX_W'(ang_s[ANGLE_BITS-3:0]);
    idx_c = ang_c[ANGLE_BITS-2] ? QIDX_W'(QUARTER) - QIDX_W'(ang_c[ANGLE_BITS-3:0])
                                : QIDX_W'(ang_c[ANGLE_BITS-3:0]);
  end

  // stages 1 and 2: extents, table read, sign
  always_ff @(posedge clk_i) begin
    px1_q   <= in_data_i.pos_x;
    py1_q   <= in_data_i.pos_y;
    hw1_q   <= in_data_i.src_w * in_data_i.scale;
    hh1_q   <= in_data_i.src_h * in_data_i.scale;
    smag1_q <= SineRom[idx_s];
    cmag1_q <= SineRom[idx_c];
    sneg1_q <= ang_s[ANGLE_BITS-1];
    cneg1_q <= ang_c[ANGLE_BITS-1];
    uea1_q  <= EDGE_W'(in_data_i.src_u);
    ueb1_q  <= EDGE_W'(in_data_i.src_u) + EDGE_W'(in_data_i.src_w);
    vea1_q  <= EDGE_W'(in_data_i.src_v);
    veb1_q  <= EDGE_W'(in_data_i.src_v) + EDGE_W'(in_data_i.src_h);
    tw1_q   <= (in_data_i.tex_width == '0) ? SIZE_W'(1) : in_data_i.tex_width;
    th1_q   <= (in_data_i.tex_height == '0) ? SIZE_W'(1) : in_data_i.tex_height;
    fh_q    <= {fh_q[4:1], in_data_i.flip_h};
    fv_q    <= {fv_q[4:1], in_data_i.flip_v};

    px2_q  <= px1_q;
    py2_q  <= py1_q;
    hw2_q  <= hw1_q;
    hh2_q  <= hh1_q;
    sin2_q <= sneg1_q ? -$signed({1'b0, smag1_q}) : $signed({1'b0, smag1_q});
    cos2_q <= cneg1_q ? -$signed({1'b0, cmag1_q}) : $signed({1'b0, cmag1_q});
  end

  // stage 3: the four products shared by all corners
  always_ff @(posedge clk_i) begin
    px3_q <= px2_q;
    py3_q <= py2_q;
    pa3_q <= $signed({1'b0, hw2_q}) * cos2_q;
    pb3_q <= $signed({1'b0, hh2_q}) * sin2_q;
    pc3_q <= $signed({1'b0, hw2_q}) * sin2_q;
    pd3_q <= $signed({1'b0, hh2_q}) * cos2_q;
  end

  // stage 4: corner offsets, dx*c - dy*s and dx*s + dy*c, plus the rounding half
  always_comb begin
    logic signed [OFF_W-1:0] a, b, c, d;
    logic sx, sy;
    for (int k = 0; k < 4; k++) begin
      sx = (corner_e'(k) == CORNER_TR) || (corner_e'(k) == CORNER_BR);
      sy = (corner_e'(k) == CORNER_BR) || (corner_e'(k) == CORNER_BL);
      a  = sx ? OFF_W'(pa3_q) : -OFF_W'(pa3_q);
      b  = sy ? OFF_W'(pb3_q) : -OFF_W'(pb3_q);
      c  = sx ? OFF_W'(pc3_q) : -OFF_W'(pc3_q);
      d  = sy ? OFF_W'(pd3_q) : -OFF_W'(pd3_q);
      ox4_d[k] = a - b + RoundHalf;
      oy4_d[k] = c + d + RoundHalf;
    end
  end

  // stage 5: translate and saturate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vx5_d[k] = place(ox4_q[k], px4_q);
      vy5_d[k] = place(oy4_q[k], py4_q);
    end
  end

  always_ff @(posedge clk_i) begin
    px4_q <= px3_q;
    py4_q <= py3_q;
    ox4_q <= ox4_d;
    oy4_q <= oy4_d;
    vx5_q <= vx5_d;
    vy5_q <= vy5_d;
  end

  sqs_tex_div u_div_ua (.clk_i(clk_i), .tedge_i(uea1_q), .size_i(tw1_q), .coord_o(ua5));
  sqs_tex_div u_div_ub (.clk_i(clk_i), .tedge_i(ueb1_q), .size_i(tw1_q), .coord_o(ub5));
  sqs_tex_div u_div_va (.clk_i(clk_i), .tedge_i(vea1_q), .size_i(th1_q), .coord_o(va5));
  sqs_tex_div u_div_vb (.clk_i(clk_i), .tedge_i(veb1_q), .size_i(th1_q), .coord_o(vb5));

  always_comb begin
    push_o = vld_q[5];
    for (int k = 0; k < 4; k++) begin
      entry_o.vx[k] = vx5_q[k];
      entry_o.vy[k] = vy5_q[k];
    end
    entry_o.ua = fh_q[5] ? ub5 : ua5;
    entry_o.ub = fh_q[5] ? ua5 : ub5;
    entry_o.va = fv_q[5] ? vb5 : va5;
    entry_o.vb = fv_q[5] ? va5 : vb5;
  end

endmodule

@@ rtl/sqs_queue.sv @@
// Short queue of finished quads between the front pipe and the vertex sequencer.
// Depends on sqs_pkg; QDEPTH entries in flops, head read directly.
module sqs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sqs_pkg::sqs_entry_t  wdata_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output logic                 full_o,
  output sqs_pkg::sqs_entry_t  rdata_o
);
  import sqs_pkg::*;

  sqs_entry_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule

@@ rtl/sqs_back.sv @@
// Back part: walks one quad through its six vertices into the output register.
// Depends on sqs_pkg; one vertex per cycle while the sink takes them.
module sqs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  sqs_pkg::sqs_entry_t  q_data_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output sqs_pkg::sqs_out_t    m_data_o,
  output logic                 m_last_o
);
  import sqs_pkg::*;

  sqs_entry_t       ent_q;
  logic             act_q;
  logic [IDX_W-1:0] idx_q;
  logic             mvalid_q;
  sqs_out_t         out_q;
  logic             last_q;

  logic     adv, fin, load;
  corner_e  k;
  sqs_out_t vtx;

  assign adv   = act_q && (!mvalid_q || m_ready_i);
  assign fin   = adv && (idx_q == IDX_W'(VERTS - 1));
  assign load  = q_valid_i && (!act_q || fin);
  assign pop_o = load;

  always_comb begin
    k            = corner_of(idx_q);
    vtx.corner   = k;
    vtx.vert_x   = ent_q.vx[k];
    vtx.vert_y   = ent_q.vy[k];
    vtx.tex_u    = (k == CORNER_TR || k == CORNER_BR) ? ent_q.ub : ent_q.ua;
    vtx.tex_v    = (k == CORNER_BR || k == CORNER_BL) ? ent_q.vb : ent_q.va;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      idx_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      if (adv)            mvalid_q <= 1'b1;
      else if (m_ready_i) mvalid_q <= 1'b0;
      if (adv) idx_q <= fin ? '0 : idx_q + 1'b1;
      // refill on the sixth vertex so the next quad starts without a gap
      if (load) begin
        act_q <= 1'b1;
        idx_q <= '0;
      end else if (fin) begin
        act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) ent_q <= q_data_i;
    if (adv) begin
      out_q  <= vtx;
      last_q <= fin;
    end
  end

  assign m_valid_o = mvalid_q;
  assign m_data_o  = out_q;
  assign m_last_o  = last_q;

endmodule

@@ rtl/sprite_quad_setup_top.sv @@
// Sprite quad setup: one draw request in, six textured vertices out.
// Depends on sqs_pkg, sqs_front, sqs_tex_div, sqs_queue and sqs_back.
//
//   channel   direction  word                         per request
//   s_axis    in         sprite request (144 bits)    one word
//   m_axis    out        vertex (80 bits) + tlast     six words, tlast on the sixth
//
// A request leaves as six vertices, one per cycle while the output is not stalled, set by
// the sequencer; the front pipe takes a new request every cycle while fewer than four
// requests sit in the pipe and the quad queue together. Reset clears the control state
// only. A stalled output holds the sequencer; the front keeps going until those four
// credits are used, then drops s_axis_tready.
module sprite_quad_setup_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[15:0] pos_y[31:16] scale[47:32] angle[59:48] flip_h[60] flip_v[61]
  // src_u[73:62] src_v[85:74] src_w[98:86] src_h[111:99] tex_width[124:112]
  // tex_height[137:125], zero fill to bit 143
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vert_x[21:0] vert_y[43:22] tex_u[60:44] tex_v[77:61] corner[79:78]
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast   // last_vertex
);
  import sqs_pkg::*;

  sqs_in_t    in_word;
  sqs_out_t   out_word;
  sqs_entry_t q_wdata, q_rdata;
  logic       q_push, q_pop, q_valid, q_full;

  assign in_word      = sqs_in_t'(s_axis_tdata);
  assign m_axis_tdata = out_word;

  sqs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (in_word),
    .pop_i      (q_pop),
    .push_o     (q_push),
    .entry_o    (q_wdata)
  );

  sqs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .rdata_o (q_rdata)
  );

  sqs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (out_word),
    .m_last_o  (m_axis_tlast)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("quad pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("quad popped from an empty queue");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (out_word.corner == CORNER_BL))
    else $error("last vertex is not the bottom-left corner");

endmodule
